### hw/rtl/angular_leader_clustering_unit_assert.svh
// assertion macros for the clustering unit checker
// include guarded, no other dependencies
`ifndef ANGULAR_LEADER_CLUSTERING_UNIT_ASSERT_SVH
`define ANGULAR_LEADER_CLUSTERING_UNIT_ASSERT_SVH

// same-cycle implication
`define ALC_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("alc assertion failed");

// next-cycle implication
`define ALC_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("alc assertion failed");

`endif

### hw/rtl/alc_pkg.sv
// shared types and constants of the clustering unit
// no dependencies
package alc_pkg;

  localparam int MAX_GROUPS_DEF = 16;
  localparam int COMPONENT_BITS = 16;
  localparam int COUNT_BITS     = 20;
  localparam int SUM_BITS       = COMPONENT_BITS + COUNT_BITS;
  localparam int MEAN_BITS      = 3 * COMPONENT_BITS;
  localparam int ENTRY_BITS     = COUNT_BITS + 3 * SUM_BITS + MEAN_BITS;
  localparam int KEY_BITS       = 16;
  localparam int IDX_OUT_BITS   = 4;
  localparam int OPEN_OUT_BITS  = 5;
  localparam int LIMIT_BITS     = 5;
  localparam int THR_BITS       = 15;
  localparam int Q_FRAC         = 14;
  localparam int ONE_Q14        = 16384;
  localparam int DOT_BITS       = 2 * COMPONENT_BITS + 2;
  localparam int NORM_TOP       = 30;
  localparam int SQ_BITS        = 2 * NORM_TOP + 2;
  localparam int ROOT_BITS      = SQ_BITS + 1;
  localparam int RT_STEPS       = SQ_BITS / 2 + 1;
  localparam int LEN_BITS       = NORM_TOP + 1;
  localparam int NUM_BITS       = NORM_TOP + Q_FRAC + 1;
  localparam int DIV_STEPS      = COMPONENT_BITS;
  localparam int STEP_BITS      = 5;
  localparam int CFG_AW         = 3;
  localparam int CFG_DW         = 32;

  localparam logic [LIMIT_BITS-1:0] GROUP_LIMIT_RST = 5'd10;
  localparam logic [THR_BITS-1:0]   COS_THR_RST     = 15'd14189;

  localparam logic [1:0] OC_JOIN    = 2'd0;
  localparam logic [1:0] OC_OPEN    = 2'd1;
  localparam logic [1:0] OC_DISCARD = 2'd2;
  localparam logic [1:0] OC_EMPTY   = 2'd3;

  localparam logic MODE_READ    = 1'b1;
  localparam logic REG_SEL_LIMIT = 1'b0;
  localparam logic REG_SEL_THR   = 1'b1;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LOAD,
    OP_RD_SCAN,
    OP_MUL,
    OP_CMP,
    OP_RD_BEST,
    OP_RD_QUERY,
    OP_UPD,
    OP_ABS,
    OP_NORM,
    OP_MEAN_ZERO,
    OP_SQ,
    OP_ACC,
    OP_RT_INIT,
    OP_RT,
    OP_DIV_INIT,
    OP_DIV,
    OP_DIV_END,
    OP_WR_JOIN,
    OP_WR_OPEN,
    OP_RES_DISCARD,
    OP_RES_READ,
    OP_RES_EMPTY,
    OP_PUSH
  } dp_op_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] comp;
  } dp_cmd_t;

  typedef struct packed {
    logic mode_read;
    logic q_ok;
    logic open_zero;
    logic scan_last;
    logic join_ok;
    logic can_open;
    logic mag_zero;
    logic norm_ok;
    logic out_free;
  } dp_status_t;

endpackage

### hw/rtl/alc_if.sv
// item channels of the clustering unit
// depends on alc_pkg
interface alc_in_if import alc_pkg::*; ();
  logic                             valid;
  logic                             ready;
  logic                             mode;
  logic signed [COMPONENT_BITS-1:0] normal_x;
  logic signed [COMPONENT_BITS-1:0] normal_y;
  logic signed [COMPONENT_BITS-1:0] normal_z;
  logic [KEY_BITS-1:0]              key_x;
  logic [KEY_BITS-1:0]              key_y;
  logic [KEY_BITS-1:0]              key_z;
  logic [IDX_OUT_BITS-1:0]          query_index;

  modport source (output valid, mode, normal_x, normal_y, normal_z, key_x, key_y, key_z,
                  query_index, input ready);
  modport sink (input valid, mode, normal_x, normal_y, normal_z, key_x, key_y, key_z,
                query_index, output ready);
endinterface

interface alc_out_if import alc_pkg::*; ();
  logic                             valid;
  logic                             ready;
  logic [IDX_OUT_BITS-1:0]          group_index;
  logic [1:0]                       outcome;
  logic [KEY_BITS-1:0]              out_key_x;
  logic [KEY_BITS-1:0]              out_key_y;
  logic [KEY_BITS-1:0]              out_key_z;
  logic [COUNT_BITS-1:0]            member_count;
  logic signed [COMPONENT_BITS-1:0] mean_x;
  logic signed [COMPONENT_BITS-1:0] mean_y;
  logic signed [COMPONENT_BITS-1:0] mean_z;
  logic [OPEN_OUT_BITS-1:0]         groups_open;

  modport source (output valid, group_index, outcome, out_key_x, out_key_y, out_key_z,
                  member_count, mean_x, mean_y, mean_z, groups_open, input ready);
  modport sink (input valid, group_index, outcome, out_key_x, out_key_y, out_key_z,
                member_count, mean_x, mean_y, mean_z, groups_open, output ready);
endinterface

### hw/rtl/alc_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module alc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

### hw/rtl/alc_ctrl.sv
// sequencer of the clustering unit: scan, join, open, discard, read
// depends on alc_pkg, drives alc_dp through dp_cmd_t
module alc_ctrl import alc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  dp_status_t st,
  output dp_cmd_t    cmd
);
  typedef enum logic [4:0] {
    S_IDLE, S_DISPATCH, S_SC_RD, S_SC_MUL, S_SC_CMP, S_DECIDE,
    S_J_RD, S_J_UPD, S_J_ABS, S_J_NORM, S_J_SQ, S_J_ACC, S_J_RTI, S_J_RT,
    S_J_DVI, S_J_DV, S_J_DVE, S_J_WR, S_RQ, S_RQW, S_OUT
  } state_t;

  state_t               state_r, state_nxt;
  logic [1:0]           comp_r, comp_nxt;
  logic [STEP_BITS-1:0] step_r, step_nxt;

  always_comb begin
    state_nxt = state_r;
    comp_nxt  = comp_r;
    step_nxt  = step_r;
    cmd.op    = OP_NONE;
    cmd.comp  = comp_r;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.op    = OP_LOAD;
          state_nxt = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (st.mode_read) begin
          if (st.q_ok) begin
            state_nxt = S_RQ;
          end else begin
            cmd.op    = OP_RES_EMPTY;
            state_nxt = S_OUT;
          end
        end else if (st.open_zero) begin
          state_nxt = S_DECIDE;
        end else begin
          state_nxt = S_SC_RD;
        end
      end
      S_SC_RD: begin
        cmd.op    = OP_RD_SCAN;
        state_nxt = S_SC_MUL;
      end
      S_SC_MUL: begin
        cmd.op    = OP_MUL;
        state_nxt = S_SC_CMP;
      end
      S_SC_CMP: begin
        cmd.op    = OP_CMP;
        state_nxt = st.scan_last ? S_DECIDE : S_SC_RD;
      end
      S_DECIDE: begin
        if (st.join_ok) begin
          state_nxt = S_J_RD;
        end else if (st.can_open) begin
          cmd.op    = OP_WR_OPEN;
          state_nxt = S_OUT;
        end else begin
          cmd.op    = OP_RES_DISCARD;
          state_nxt = S_OUT;
        end
      end
      S_J_RD: begin
        cmd.op    = OP_RD_BEST;
        state_nxt = S_J_UPD;
      end
      S_J_UPD: begin
        cmd.op    = OP_UPD;
        state_nxt = S_J_ABS;
      end
      S_J_ABS: begin
        cmd.op    = OP_ABS;
        state_nxt = S_J_NORM;
      end
      S_J_NORM: begin
        if (st.mag_zero) begin
          cmd.op    = OP_MEAN_ZERO;
          state_nxt = S_J_WR;
        end else begin
          cmd.op = OP_NORM;
          if (st.norm_ok) begin
            comp_nxt  = 2'd0;
            state_nxt = S_J_SQ;
          end
        end
      end
      S_J_SQ: begin
        cmd.op    = OP_SQ;
        state_nxt = S_J_ACC;
      end
      S_J_ACC: begin
        cmd.op = OP_ACC;
        if (comp_r == 2'd2) begin
          state_nxt = S_J_RTI;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_J_SQ;
        end
      end
      S_J_RTI: begin
        cmd.op    = OP_RT_INIT;
        step_nxt  = '0;
        state_nxt = S_J_RT;
      end
      S_J_RT: begin
        cmd.op = OP_RT;
        if (step_r == STEP_BITS'(RT_STEPS - 1)) begin
          comp_nxt  = 2'd0;
          state_nxt = S_J_DVI;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_J_DVI: begin
        cmd.op    = OP_DIV_INIT;
        step_nxt  = '0;
        state_nxt = S_J_DV;
      end
      S_J_DV: begin
        cmd.op = OP_DIV;
        if (step_r == STEP_BITS'(DIV_STEPS - 1)) begin
          state_nxt = S_J_DVE;
        end else begin
          step_nxt = step_r + 1'b1;
        end
      end
      S_J_DVE: begin
        cmd.op = OP_DIV_END;
        if (comp_r == 2'd2) begin
          state_nxt = S_J_WR;
        end else begin
          comp_nxt  = comp_r + 2'd1;
          state_nxt = S_J_DVI;
        end
      end
      S_J_WR: begin
        cmd.op    = OP_WR_JOIN;
        state_nxt = S_OUT;
      end
      S_RQ: begin
        cmd.op    = OP_RD_QUERY;
        state_nxt = S_RQW;
      end
      S_RQW: begin
        cmd.op    = OP_RES_READ;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (st.out_free) begin
          cmd.op    = OP_PUSH;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      comp_r  <= 2'd0;
      step_r  <= '0;
    end else begin
      state_r <= state_nxt;
      comp_r  <= comp_nxt;
      step_r  <= step_nxt;
    end
  end
endmodule

### hw/rtl/alc_dp.sv
// datapath of the clustering unit: group store, dot products, renormalising
// depends on alc_pkg and alc_ram, steered by alc_ctrl
module alc_dp import alc_pkg::*; #(
  parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dp_cmd_t                          cmd,
  output dp_status_t                       st,
  input  logic [LIMIT_BITS-1:0]            group_limit,
  input  logic [THR_BITS-1:0]              cos_threshold,
  input  logic                             in_mode,
  input  logic signed [COMPONENT_BITS-1:0] in_normal [3],
  input  logic [KEY_BITS-1:0]              in_key [3],
  input  logic [IDX_OUT_BITS-1:0]          in_query_index,
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic [IDX_OUT_BITS-1:0]          out_group_index,
  output logic [1:0]                       out_outcome,
  output logic [KEY_BITS-1:0]              out_key [3],
  output logic [COUNT_BITS-1:0]            out_member_count,
  output logic signed [COMPONENT_BITS-1:0] out_mean [3],
  output logic [OPEN_OUT_BITS-1:0]         out_groups_open
);
  localparam int IW  = (MAX_GROUPS > 1) ? $clog2(MAX_GROUPS) : 1;
  localparam int OW  = $clog2(MAX_GROUPS + 1);
  localparam int CW  = ((OW > LIMIT_BITS) ? OW : LIMIT_BITS) + 1;
  localparam logic [COUNT_BITS-1:0]     CNT_MAX = '1;
  localparam logic [COMPONENT_BITS-1:0] ONE     = COMPONENT_BITS'(ONE_Q14);

  function automatic logic signed [SUM_BITS-1:0] sat_add(
    input logic signed [SUM_BITS-1:0]       a,
    input logic signed [COMPONENT_BITS-1:0] b
  );
    logic signed [SUM_BITS:0] s;
    s = (SUM_BITS+1)'(a) + (SUM_BITS+1)'(b);
    if (s[SUM_BITS] != s[SUM_BITS-1]) begin
      sat_add = s[SUM_BITS] ? {1'b1, {(SUM_BITS-1){1'b0}}} : {1'b0, {(SUM_BITS-1){1'b1}}};
    end else begin
      sat_add = s[SUM_BITS-1:0];
    end
  endfunction

  // latched item
  logic                             mode_r;
  logic signed [COMPONENT_BITS-1:0] n_r [3];
  logic [KEY_BITS-1:0]              key_r [3];
  logic [IDX_OUT_BITS-1:0]          q_r;

  // control state
  logic [OW-1:0] open_r;
  logic          out_valid_r;

  // scan
  logic [IW-1:0]                     idx_r, best_r;
  logic                              have_r;
  logic signed [DOT_BITS-1:0]        best_dot_r;
  logic signed [2*COMPONENT_BITS-1:0] prod_r [3];

  // join arithmetic
  logic [COUNT_BITS-1:0]      cnt_r;
  logic signed [SUM_BITS-1:0] sum_r [3];
  logic [SUM_BITS-1:0]        mag_r [3];
  logic [2*NORM_TOP-1:0]      sqp_r;
  logic [SQ_BITS-1:0]         sq_r;
  logic [ROOT_BITS-1:0]       rv_r, res_r, bit_r;
  logic [LEN_BITS:0]          rem_r;
  logic [DIV_STEPS-1:0]       nlo_r;
  logic signed [COMPONENT_BITS-1:0] mean_r [3];

  // staged and registered result
  logic [IDX_OUT_BITS-1:0]          rs_idx_r, o_idx_r;
  logic [1:0]                       rs_oc_r, o_oc_r;
  logic [KEY_BITS-1:0]              rs_key_r [3], o_key_r [3];
  logic [COUNT_BITS-1:0]            rs_cnt_r, o_cnt_r;
  logic signed [COMPONENT_BITS-1:0] rs_mean_r [3], o_mean_r [3];
  logic [OPEN_OUT_BITS-1:0]         rs_gopen_r, o_gopen_r;

  // store
  logic                  ram_we;
  logic [IW-1:0]         ram_waddr, ram_raddr;
  logic [ENTRY_BITS-1:0] ram_wdata, ram_rdata;

  logic signed [COMPONENT_BITS-1:0] rd_mean [3];
  logic signed [SUM_BITS-1:0]       rd_sum [3];
  logic [COUNT_BITS-1:0]            rd_cnt;
  logic signed [DOT_BITS-1:0]       dot, thr_dot;
  logic [SUM_BITS-1:0]              mag_or;
  logic                             mag_hi;
  logic [ROOT_BITS-1:0]             rt_try;
  logic [LEN_BITS-1:0]              len;
  logic [NUM_BITS-1:0]              num;
  logic [LEN_BITS:0]                r2;
  logic                             r2_ge;
  logic [COMPONENT_BITS-1:0]        qcap;

  alc_ram #(.WIDTH(ENTRY_BITS), .DEPTH(MAX_GROUPS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      rd_mean[c] = ram_rdata[c*COMPONENT_BITS +: COMPONENT_BITS];
      rd_sum[c]  = ram_rdata[MEAN_BITS + c*SUM_BITS +: SUM_BITS];
    end
    rd_cnt = ram_rdata[MEAN_BITS + 3*SUM_BITS +: COUNT_BITS];
  end

  assign dot = DOT_BITS'(prod_r[0]) + DOT_BITS'(prod_r[1]) + DOT_BITS'(prod_r[2]);
  assign thr_dot = $signed(DOT_BITS'({cos_threshold, {Q_FRAC{1'b0}}}));
  assign mag_or = mag_r[0] | mag_r[1] | mag_r[2];
  assign mag_hi = |mag_or[SUM_BITS-1:NORM_TOP];
  assign rt_try = res_r + bit_r;
  assign len    = res_r[LEN_BITS-1:0];
  assign num    = NUM_BITS'({mag_r[cmd.comp][NORM_TOP-1:0], {Q_FRAC{1'b0}}})
                + NUM_BITS'(len >> 1);
  assign r2     = {rem_r[LEN_BITS-1:0], nlo_r[DIV_STEPS-1]};
  assign r2_ge  = r2 >= {1'b0, len};
  assign qcap   = (nlo_r > ONE) ? ONE : nlo_r;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = best_r;
    ram_wdata = {cnt_r, sum_r[2], sum_r[1], sum_r[0], mean_r[2], mean_r[1], mean_r[0]};
    case (cmd.op)
      OP_WR_JOIN: begin
        ram_we = 1'b1;
      end
      OP_WR_OPEN: begin
        ram_we    = 1'b1;
        ram_waddr = IW'(open_r);
        ram_wdata = {COUNT_BITS'(1), SUM_BITS'(n_r[2]), SUM_BITS'(n_r[1]),
                     SUM_BITS'(n_r[0]), n_r[2], n_r[1], n_r[0]};
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_comb begin
    case (cmd.op)
      OP_RD_QUERY: ram_raddr = IW'(q_r);
      OP_RD_BEST:  ram_raddr = best_r;
      default:     ram_raddr = idx_r;
    endcase
  end

  always_comb begin
    st.mode_read = (mode_r == MODE_READ);
    st.q_ok      = CW'(q_r) < CW'(open_r);
    st.open_zero = (open_r == '0);
    st.scan_last = (CW'(idx_r) + CW'(1)) >= CW'(open_r);
    st.join_ok   = have_r && (best_dot_r >= thr_dot);
    st.can_open  = (CW'(open_r) < CW'(group_limit)) && (CW'(open_r) < CW'(MAX_GROUPS));
    st.mag_zero  = (mag_or == '0);
    st.norm_ok   = !mag_hi && mag_or[NORM_TOP-1];
    st.out_free  = !out_valid_r || out_ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.op == OP_WR_OPEN) begin
        open_r <= open_r + 1'b1;
      end
      if (cmd.op == OP_PUSH) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mode_r <= in_mode;
        n_r    <= in_normal;
        key_r  <= in_key;
        q_r    <= in_query_index;
        idx_r  <= '0;
        have_r <= 1'b0;
      end
      OP_MUL: begin
        for (int c = 0; c < 3; c++) begin
          prod_r[c] <= n_r[c] * rd_mean[c];
        end
      end
      OP_CMP: begin
        if (!have_r || dot > best_dot_r) begin
          have_r     <= 1'b1;
          best_r     <= idx_r;
          best_dot_r <= dot;
        end
        idx_r <= idx_r + 1'b1;
      end
      OP_UPD: begin
        cnt_r <= (rd_cnt == CNT_MAX) ? rd_cnt : rd_cnt + 1'b1;
        for (int c = 0; c < 3; c++) begin
          sum_r[c] <= sat_add(rd_sum[c], n_r[c]);
        end
      end
      OP_ABS: begin
        for (int c = 0; c < 3; c++) begin
          mag_r[c] <= sum_r[c][SUM_BITS-1] ? SUM_BITS'(-sum_r[c]) : SUM_BITS'(sum_r[c]);
        end
      end
      OP_NORM: begin
        sq_r <= '0;
        for (int c = 0; c < 3; c++) begin
          if (mag_hi) begin
            mag_r[c] <= mag_r[c] >> 1;
          end else if (!mag_or[NORM_TOP-1]) begin
            mag_r[c] <= mag_r[c] << 1;
          end
        end
      end
      OP_MEAN_ZERO: begin
        for (int c = 0; c < 3; c++) begin
          mean_r[c] <= '0;
        end
      end
      OP_SQ: begin
        sqp_r <= mag_r[cmd.comp][NORM_TOP-1:0] * mag_r[cmd.comp][NORM_TOP-1:0];
      end
      OP_ACC: begin
        sq_r <= sq_r + SQ_BITS'(sqp_r);
      end
      OP_RT_INIT: begin
        rv_r  <= ROOT_BITS'(sq_r);
        res_r <= '0;
        bit_r <= {1'b1, {(ROOT_BITS-1){1'b0}}};
      end
      OP_RT: begin
        if (rv_r >= rt_try) begin
          rv_r  <= rv_r - rt_try;
          res_r <= (res_r >> 1) + bit_r;
        end else begin
          res_r <= res_r >> 1;
        end
        bit_r <= bit_r >> 2;
      end
      OP_DIV_INIT: begin
        rem_r <= (LEN_BITS+1)'(num[NUM_BITS-1:DIV_STEPS]);
        nlo_r <= num[DIV_STEPS-1:0];
      end
      OP_DIV: begin
        rem_r <= r2_ge ? r2 - {1'b0, len} : r2;
        nlo_r <= {nlo_r[DIV_STEPS-2:0], r2_ge};
      end
      OP_DIV_END: begin
        mean_r[cmd.comp] <= sum_r[cmd.comp][SUM_BITS-1] ? -$signed(qcap) : $signed(qcap);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_WR_JOIN: begin
        rs_idx_r   <= IDX_OUT_BITS'(best_r);
        rs_oc_r    <= OC_JOIN;
        rs_key_r   <= key_r;
        rs_cnt_r   <= cnt_r;
        rs_mean_r  <= mean_r;
        rs_gopen_r <= OPEN_OUT_BITS'(open_r);
      end
      OP_WR_OPEN: begin
        rs_idx_r   <= IDX_OUT_BITS'(open_r);
        rs_oc_r    <= OC_OPEN;
        rs_key_r   <= key_r;
        rs_cnt_r   <= COUNT_BITS'(1);
        rs_mean_r  <= n_r;
        rs_gopen_r <= OPEN_OUT_BITS'(open_r + 1'b1);
      end
      OP_RES_DISCARD: begin
        rs_idx_r   <= '0;
        rs_oc_r    <= OC_DISCARD;
        rs_key_r   <= key_r;
        rs_cnt_r   <= '0;
        rs_mean_r  <= '{default: '0};
        rs_gopen_r <= OPEN_OUT_BITS'(open_r);
      end
      OP_RES_READ: begin
        rs_idx_r   <= q_r;
        rs_oc_r    <= OC_JOIN;
        rs_key_r   <= '{default: '0};
        rs_cnt_r   <= rd_cnt;
        rs_mean_r  <= rd_mean;
        rs_gopen_r <= OPEN_OUT_BITS'(open_r);
      end
      OP_RES_EMPTY: begin
        rs_idx_r   <= q_r;
        rs_oc_r    <= OC_EMPTY;
        rs_key_r   <= '{default: '0};
        rs_cnt_r   <= '0;
        rs_mean_r  <= '{default: '0};
        rs_gopen_r <= OPEN_OUT_BITS'(open_r);
      end
      OP_PUSH: begin
        o_idx_r   <= rs_idx_r;
        o_oc_r    <= rs_oc_r;
        o_key_r   <= rs_key_r;
        o_cnt_r   <= rs_cnt_r;
        o_mean_r  <= rs_mean_r;
        o_gopen_r <= rs_gopen_r;
      end
      default: begin
      end
    endcase
  end

  assign out_valid        = out_valid_r;
  assign out_group_index  = o_idx_r;
  assign out_outcome      = o_oc_r;
  assign out_key          = o_key_r;
  assign out_member_count = o_cnt_r;
  assign out_mean         = o_mean_r;
  assign out_groups_open  = o_gopen_r;
endmodule

### hw/rtl/angular_leader_clustering_unit.sv
// Clustering of unit normals by cosine to each open group's mean direction. One item is
// worked on at a time. A read of an open slot reads the store and then stages its result, a
// read of an empty slot stages an empty result. An assign item scans each open group in turn
// (store read, three products, compare), then joins the best group, opens a group or discards.
// A join adds the renormalising sequence: a one-bit-a-cycle normalising shift, three squares,
// a 32-step square root and three 16-step divides. The output register lets the next item
// start while the last result waits.
// Depends on alc_pkg, alc_if, alc_ctrl and alc_dp.
module angular_leader_clustering_unit import alc_pkg::*; #(
  parameter int MAX_GROUPS = MAX_GROUPS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  alc_in_if.sink            in_item,
  alc_out_if.source         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);
  logic [LIMIT_BITS-1:0] limit_r;
  logic [THR_BITS-1:0]   thr_r;
  dp_cmd_t               cmd;
  dp_status_t            st;

  logic signed [COMPONENT_BITS-1:0] in_normal [3];
  logic [KEY_BITS-1:0]              in_key [3];
  logic [KEY_BITS-1:0]              o_key [3];
  logic signed [COMPONENT_BITS-1:0] o_mean [3];

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= GROUP_LIMIT_RST;
      thr_r   <= COS_THR_RST;
    end else if (psel && penable && pwrite) begin
      case (paddr[2])
        REG_SEL_LIMIT: limit_r <= pwdata[LIMIT_BITS-1:0];
        REG_SEL_THR:   thr_r   <= pwdata[THR_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  assign prdata = (paddr[2] == REG_SEL_THR) ? CFG_DW'(thr_r) : CFG_DW'(limit_r);

  assign in_normal = '{in_item.normal_x, in_item.normal_y, in_item.normal_z};
  assign in_key    = '{in_item.key_x, in_item.key_y, in_item.key_z};

  alc_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_item.valid),
    .in_ready (in_item.ready),
    .st       (st),
    .cmd      (cmd)
  );

  alc_dp #(.MAX_GROUPS(MAX_GROUPS)) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .group_limit      (limit_r),
    .cos_threshold    (thr_r),
    .in_mode          (in_item.mode),
    .in_normal        (in_normal),
    .in_key           (in_key),
    .in_query_index   (in_item.query_index),
    .out_valid        (out_item.valid),
    .out_ready        (out_item.ready),
    .out_group_index  (out_item.group_index),
    .out_outcome      (out_item.outcome),
    .out_key          (o_key),
    .out_member_count (out_item.member_count),
    .out_mean         (o_mean),
    .out_groups_open  (out_item.groups_open)
  );

  assign out_item.out_key_x = o_key[0];
  assign out_item.out_key_y = o_key[1];
  assign out_item.out_key_z = o_key[2];
  assign out_item.mean_x    = o_mean[0];
  assign out_item.mean_y    = o_mean[1];
  assign out_item.mean_z    = o_mean[2];
endmodule

### hw/rtl/alc_checker.sv
// port-level checks of the clustering unit, bound to the top level
// depends on alc_pkg and angular_leader_clustering_unit_assert.svh
`include "angular_leader_clustering_unit_assert.svh"

module alc_checker import alc_pkg::*; (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [1:0]              outcome,
  input logic [IDX_OUT_BITS-1:0] group_index,
  input logic [COUNT_BITS-1:0]   member_count
);
  `ALC_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  `ALC_ASSERT_IMP(a_discard_empty, clk, rst_n, out_valid && outcome == OC_DISCARD, group_index == '0 && member_count == '0)
  `ALC_ASSERT_IMP(a_open_single, clk, rst_n, out_valid && outcome == OC_OPEN, member_count == COUNT_BITS'(1))
  `ALC_ASSERT_IMP(a_join_nonzero, clk, rst_n, out_valid && outcome == OC_JOIN, member_count != '0)
endmodule

bind angular_leader_clustering_unit alc_checker u_alc_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_item.valid),
  .out_ready    (out_item.ready),
  .outcome      (out_item.outcome),
  .group_index  (out_item.group_index),
  .member_count (out_item.member_count)
);
